// ===== rtl/frt_pkg.sv =====
// ---------------------------------------------------------------------------
// frt_pkg
// Shared types and constants for the fragment reassembly tracker.
// ---------------------------------------------------------------------------
package frt_pkg;

   localparam int Contexts  = 16;
   localparam int MaxFrags  = 64;
   localparam int SlotW     = $clog2(Contexts);
   localparam int SlotCntW  = $clog2(Contexts + 1);

   localparam logic [15:0] TimeoutReset = 16'd10000;
   localparam logic [15:0] AgeMax       = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_PASS     = 3'd0,
      ST_HELD     = 3'd1,
      ST_DONE     = 3'd2,
      ST_BADNUM   = 3'd3,
      ST_NOTFIRST = 3'd4,
      ST_TOOMANY  = 3'd5,
      ST_ERROR    = 3'd6,
      ST_FULL     = 3'd7
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic             load;      // capture request fields
      logic             clr_scan;  // reset scan index and search results
      logic             scan;      // evaluate slot at scan index, advance
      logic             age;       // age/expire slot at scan index, advance
      logic             open;      // open context in free slot
      logic             absorb;    // absorb fragment into hit slot
      logic             emit;      // drive a response for one cycle
      status_type       status;    // response code used by emit
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic kind;
      logic single;      // total <= 1
      logic num_over;    // number > total
      logic num_one;
      logic too_many;    // total > MaxFrags
      logic scan_last;
      logic hit;
      logic free_found;
   } sts_type;

endpackage

// ===== rtl/frt_datapath.sv =====
// ---------------------------------------------------------------------------
// frt_datapath
// Context table, slot scan and absorb arithmetic.
// ---------------------------------------------------------------------------
module frt_datapath import frt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        req_kind,
   input  logic [31:0] req_packet_id,
   input  logic [7:0]  req_fragment_number,
   input  logic [7:0]  req_fragment_total,
   input  logic [15:0] req_fragment_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_timeout_ticks,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_result_id,
   output logic [21:0] rsp_total_length,
   output logic [6:0]  rsp_fragment_count
);

   logic [15:0] timeout_ff;
   logic        kind_ff;
   logic [31:0] id_ff;
   logic [7:0]  num_ff;
   logic [7:0]  tot_ff;
   logic [15:0] len_ff;

   logic [Contexts-1:0] valid_ff;
   logic [31:0] sid_ff  [Contexts];
   logic [6:0]  sexp_ff [Contexts];
   logic [6:0]  scnt_ff [Contexts];
   logic [21:0] slen_ff [Contexts];
   logic [63:0] sseen_ff[Contexts];
   logic        sbad_ff [Contexts];
   logic [15:0] sage_ff [Contexts];

   logic [SlotCntW-1:0] idx_ff;
   logic [SlotW-1:0]    hit_slot_ff, free_slot_ff;
   logic                hit_ff, free_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [31:0] rsp_id_ff;
   logic [21:0] rsp_len_ff;
   logic [6:0]  rsp_cnt_ff;

   logic [SlotW-1:0] idx;
   assign idx = idx_ff[SlotW-1:0];

   assign csr_ready = 1'b1;

   // absorb path: slot fields of the chosen slot (open or hit)
   logic [SlotW-1:0] a_slot;
   logic [6:0]  a_exp, a_cnt, a_cnt_in;
   logic [21:0] a_len, a_len_in;
   logic [63:0] a_seen, a_bit;
   logic        a_bad, a_oob, a_bad_in, a_fin;
   logic [15:0] age_in;

   always_comb begin
      a_slot = cmd.open ? free_slot_ff : hit_slot_ff;
      if (cmd.open) begin
         a_exp  = tot_ff[6:0];
         a_cnt  = '0;
         a_len  = '0;
         a_seen = '0;
         a_bad  = 1'b0;
      end else begin
         a_exp  = sexp_ff[a_slot];
         a_cnt  = scnt_ff[a_slot];
         a_len  = slen_ff[a_slot];
         a_seen = sseen_ff[a_slot];
         a_bad  = sbad_ff[a_slot];
      end
      a_oob    = (num_ff == 8'd0) || (num_ff > {1'b0, a_exp}) || (num_ff > 8'd64);
      a_bit    = a_oob ? 64'd0 : (64'd1 << (num_ff[5:0] - 6'd1));
      a_bad_in = a_bad || a_oob || ((a_seen & a_bit) != 64'd0);
      a_cnt_in = a_cnt + 7'd1;
      a_len_in = a_len + {6'd0, len_ff};
      a_fin    = a_cnt_in >= a_exp;
      age_in   = (sage_ff[idx] < AgeMax) ? sage_ff[idx] + 16'd1 : sage_ff[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TimeoutReset;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.open || cmd.absorb || cmd.emit;
         if (csr_valid) begin
            timeout_ff <= csr_timeout_ticks;
         end
         if (cmd.load) begin
            kind_ff <= req_kind;
            id_ff   <= req_packet_id;
            num_ff  <= req_fragment_number;
            tot_ff  <= req_fragment_total;
            len_ff  <= req_fragment_length;
         end
         if (cmd.clr_scan) begin
            idx_ff  <= '0;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end
         if (cmd.scan) begin
            idx_ff <= idx_ff + 1'b1;
            if (valid_ff[idx] && sid_ff[idx] == id_ff) begin
               hit_ff      <= 1'b1;
               hit_slot_ff <= idx;
            end
            if (!valid_ff[idx] && !free_ff) begin
               free_ff      <= 1'b1;
               free_slot_ff <= idx;
            end
         end
         if (cmd.age) begin
            idx_ff <= idx_ff + 1'b1;
            if (valid_ff[idx]) begin
               sage_ff[idx] <= age_in;
               if (age_in >= timeout_ff) begin
                  valid_ff[idx] <= 1'b0;
               end
            end
         end
         if (cmd.open || cmd.absorb) begin
            sid_ff[a_slot]   <= id_ff;
            sexp_ff[a_slot]  <= a_exp;
            scnt_ff[a_slot]  <= a_cnt_in;
            slen_ff[a_slot]  <= a_len_in;
            sseen_ff[a_slot] <= a_seen | a_bit;
            sbad_ff[a_slot]  <= a_bad_in;
            if (cmd.open) begin
               sage_ff[a_slot] <= '0;
            end
            valid_ff[a_slot] <= !a_fin;
            rsp_status_ff    <= !a_fin ? ST_HELD : (a_bad_in ? ST_ERROR : ST_DONE);
            rsp_id_ff        <= id_ff;
            rsp_len_ff       <= a_len_in;
            rsp_cnt_ff       <= a_cnt_in;
         end else if (cmd.emit) begin
            rsp_status_ff <= cmd.status;
            rsp_id_ff     <= id_ff;
            rsp_len_ff    <= (cmd.status == ST_PASS) ? {6'd0, len_ff} : '0;
            rsp_cnt_ff    <= '0;
         end
      end
   end

   always_comb begin
      sts.kind       = kind_ff;
      sts.single     = tot_ff <= 8'd1;
      sts.num_over   = num_ff > tot_ff;
      sts.num_one    = num_ff == 8'd1;
      sts.too_many   = tot_ff > 8'(MaxFrags);
      sts.scan_last  = idx_ff == SlotCntW'(Contexts - 1);
      sts.hit        = hit_ff;
      sts.free_found = free_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_id      = rsp_id_ff;
   assign rsp_total_length   = rsp_len_ff;
   assign rsp_fragment_count = rsp_cnt_ff;

endmodule

// ===== rtl/frt_ctrl.sv =====
// ---------------------------------------------------------------------------
// frt_ctrl
// Request sequencer: classify, scan the table, then respond or update.
// ---------------------------------------------------------------------------
module frt_ctrl import frt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_CLASSIFY, S_SCAN, S_AGE, S_DECIDE
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE:     if (start) state_ff <= S_CLASSIFY;
            S_CLASSIFY: begin
               if (sts.kind)                      state_ff <= S_AGE;
               else if (sts.single || sts.num_over) state_ff <= S_IDLE;
               else                               state_ff <= S_SCAN;
            end
            S_SCAN:     if (sts.scan_last) state_ff <= S_DECIDE;
            S_AGE:      if (sts.scan_last) state_ff <= S_IDLE;
            S_DECIDE:   state_ff <= S_IDLE;
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = state_ff != S_IDLE;

   always_comb begin
      cmd = '0;
      cmd.status = ST_PASS;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = start;
         end
         S_CLASSIFY: begin
            cmd.clr_scan = 1'b1;
            if (!sts.kind) begin
               if (sts.single) begin
                  cmd.emit = 1'b1;
               end else if (sts.num_over) begin
                  cmd.emit   = 1'b1;
                  cmd.status = ST_BADNUM;
               end
            end
         end
         S_SCAN: cmd.scan = 1'b1;
         S_AGE:  cmd.age  = 1'b1;
         S_DECIDE: begin
            if (sts.hit) begin
               cmd.absorb = 1'b1;
            end else if (!sts.num_one) begin
               cmd.emit = 1'b1;
               cmd.status = ST_NOTFIRST;
            end else if (sts.too_many) begin
               cmd.emit = 1'b1;
               cmd.status = ST_TOOMANY;
            end else if (!sts.free_found) begin
               cmd.emit = 1'b1;
               cmd.status = ST_FULL;
            end else begin
               cmd.open = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/fragment_reassembly_tracker.sv =====
// ---------------------------------------------------------------------------
// fragment_reassembly_tracker
// Reassembly context table with sequential slot scan and tick aging.
// ---------------------------------------------------------------------------
// Early drops respond after classification, other fragments after the table scan.
// One request at a time (busy until done); early drops skip the table walk, while
//   fragments and ticks use the one-slot-per-cycle walk over the 16 contexts.
// Results are strobed on rsp_valid for one cycle; the receiver cannot stall.
// Reset clears all contexts and loads timeout_ticks with 10000.
module fragment_reassembly_tracker import frt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_packet_id,
   input  logic [7:0]  req_fragment_number,
   input  logic [7:0]  req_fragment_total,
   input  logic [15:0] req_fragment_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_timeout_ticks,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_result_id,
   output logic [21:0] rsp_total_length,
   output logic [6:0]  rsp_fragment_count
);

   cmd_type cmd;
   sts_type sts;

   frt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   frt_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_kind            (req_kind),
      .req_packet_id       (req_packet_id),
      .req_fragment_number (req_fragment_number),
      .req_fragment_total  (req_fragment_total),
      .req_fragment_length (req_fragment_length),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_timeout_ticks   (csr_timeout_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_result_id       (rsp_result_id),
      .rsp_total_length    (rsp_total_length),
      .rsp_fragment_count  (rsp_fragment_count)
   );

endmodule
